/* rtl/button_multi_press_gesture_defines.svh */
// Assertion macros for the button gesture detector checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef BUTTON_MULTI_PRESS_GESTURE_DEFINES_SVH
`define BUTTON_MULTI_PRESS_GESTURE_DEFINES_SVH

// same-cycle implication
`define BMPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bmpg_pkg.sv */
// Package for the button gesture detector: widths, register indexes, reset values.
// No dependencies.
package bmpg_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 2;
    localparam int TIMER_BITS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] GAP_RST      = 16'd400;

    localparam logic [COUNT_W-1:0] COUNT_ZERO  = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE   = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TRIPLE = 2'd3;

endpackage

/* rtl/bmpg_if.sv */
// Handshake channels of the button gesture detector: samples, results, configuration.
// Depends on bmpg_pkg.
interface bmpg_in_if;
    logic valid;
    logic ready;
    logic pressed;

    modport source (output valid, output pressed, input ready);
    modport sink   (input valid, input pressed, output ready);
endinterface

interface bmpg_out_if;
    logic                         valid;
    logic                         ready;
    logic [bmpg_pkg::COUNT_W-1:0] press_count;
    logic                         long_hold;

    modport source (output valid, output press_count, output long_hold, input ready);
    modport sink   (input valid, input press_count, input long_hold, output ready);
endinterface

interface bmpg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bmpg_pkg::CFG_IDX_W-1:0] index;
    logic [bmpg_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/button_multi_press_gesture.sv */
// Button gesture detector: debounced multi-press and long-press reporting.
// Depends on bmpg_pkg and the channel interfaces in bmpg_if.sv.
// A result is registered and shown in the cycle after the sample transfer that causes it.
// Throughput: one sample per cycle unless a held result stalls the input; the phase/timer
// update and the result register sit behind saturating adds and compares.
// Reset: asynchronous, active low; phase idle, timers clear, config registers to defaults.
module button_multi_press_gesture #(
    parameter int TIMER_BITS = bmpg_pkg::TIMER_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    bmpg_in_if.sink           gesture_in,
    bmpg_out_if.source        gesture_out,
    bmpg_cfg_if.sink          cfg
);
    import bmpg_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HOLD,
        PH_GAP,
        PH_REPEAT
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_BITS-1:0]  db_reg, db_next;
    logic [TIMER_BITS-1:0]  pt_reg, pt_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [COUNT_W-1:0]     long_cnt_reg, long_cnt_next;
    logic [CFG_W-1:0]       debounce_reg, long_reg, gap_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                   out_long_reg, out_long_next;

    logic                   accept;
    logic                   res_valid;
    logic [COUNT_W-1:0]     res_cnt;
    logic                   res_long;

    logic [CMP_W-1:0]       tmax_c, lim_db, lim_long, lim_gap;
    logic [TIMER_BITS-1:0]  db_inc, pt_inc;
    logic                   db_hit;

    assign tmax_c   = CMP_W'(TMAX);
    assign lim_db   = (CMP_W'(debounce_reg) > tmax_c) ? tmax_c : CMP_W'(debounce_reg);
    assign lim_long = (CMP_W'(long_reg) > tmax_c) ? tmax_c : CMP_W'(long_reg);
    assign lim_gap  = (CMP_W'(gap_reg) > tmax_c) ? tmax_c : CMP_W'(gap_reg);

    assign db_inc = (db_reg == TMAX) ? db_reg : db_reg + TIMER_BITS'(1);
    assign pt_inc = (pt_reg == TMAX) ? pt_reg : pt_reg + TIMER_BITS'(1);
    assign db_hit = gesture_in.pressed && (CMP_W'(db_inc) >= lim_db);

    assign gesture_in.ready = !out_valid_reg || gesture_out.ready;
    assign accept           = gesture_in.valid && gesture_in.ready;
    assign cfg.ready        = 1'b1;

    assign gesture_out.valid       = out_valid_reg;
    assign gesture_out.press_count = out_cnt_reg;
    assign gesture_out.long_hold   = out_long_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        db_next       = db_reg;
        pt_next       = pt_reg;
        cnt_next      = cnt_reg;
        long_cnt_next = long_cnt_reg;
        res_valid     = 1'b0;
        res_cnt       = COUNT_ZERO;
        res_long      = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!gesture_in.pressed)
                begin
                    db_next = '0;
                end
                else if (db_hit)
                begin
                    db_next    = '0;
                    phase_next = PH_HOLD;
                    pt_next    = '0;
                    cnt_next   = COUNT_ONE;
                end
                else
                begin
                    db_next = db_inc;
                end
            end
            PH_HOLD:
            begin
                if (gesture_in.pressed)
                begin
                    if (CMP_W'(pt_inc) >= lim_long)
                    begin
                        long_cnt_next = cnt_reg;
                        phase_next    = PH_REPEAT;
                        pt_next       = '0;
                        db_next       = '0;
                        res_valid     = 1'b1;
                        res_cnt       = cnt_reg;
                        res_long      = 1'b1;
                    end
                    else
                    begin
                        pt_next = pt_inc;
                    end
                end
                else if (cnt_reg == COUNT_TRIPLE)
                begin
                    phase_next    = PH_IDLE;
                    db_next       = '0;
                    pt_next       = '0;
                    cnt_next      = COUNT_ZERO;
                    long_cnt_next = COUNT_ZERO;
                    res_valid     = 1'b1;
                    res_cnt       = COUNT_TRIPLE;
                end
                else
                begin
                    phase_next = PH_GAP;
                    pt_next    = '0;
                    db_next    = '0;
                end
            end
            PH_GAP:
            begin
                if (db_reg == '0 && CMP_W'(pt_reg) >= lim_gap)
                begin
                    // gap over: report, then treat this sample as in idle
                    res_valid     = 1'b1;
                    res_cnt       = cnt_reg;
                    phase_next    = PH_IDLE;
                    db_next       = '0;
                    pt_next       = '0;
                    cnt_next      = COUNT_ZERO;
                    long_cnt_next = COUNT_ZERO;
                    if (gesture_in.pressed)
                    begin
                        if (lim_db <= CMP_W'(1))
                        begin
                            phase_next = PH_HOLD;
                            cnt_next   = COUNT_ONE;
                        end
                        else
                        begin
                            db_next = TIMER_BITS'(1);
                        end
                    end
                end
                else
                begin
                    pt_next = pt_inc;
                    if (!gesture_in.pressed)
                    begin
                        db_next = '0;
                    end
                    else if (db_hit)
                    begin
                        db_next    = '0;
                        phase_next = PH_HOLD;
                        pt_next    = '0;
                        cnt_next   = cnt_reg + COUNT_ONE;
                    end
                    else
                    begin
                        db_next = db_inc;
                    end
                end
            end
            PH_REPEAT:
            begin
                if (!gesture_in.pressed)
                begin
                    phase_next    = PH_IDLE;
                    db_next       = '0;
                    pt_next       = '0;
                    cnt_next      = COUNT_ZERO;
                    long_cnt_next = COUNT_ZERO;
                    res_valid     = 1'b1;
                    res_cnt       = COUNT_ZERO;
                end
                else if (CMP_W'(db_reg) < lim_db)
                begin
                    db_next = db_inc;
                end
                else if (CMP_W'(pt_inc) >= lim_long)
                begin
                    db_next   = '0;
                    pt_next   = '0;
                    res_valid = 1'b1;
                    res_cnt   = long_cnt_reg;
                    res_long  = 1'b1;
                end
                else
                begin
                    pt_next = pt_inc;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_cnt_next   = out_cnt_reg;
        out_long_next  = out_long_reg;
        if (accept)
        begin
            out_valid_next = res_valid;
            out_cnt_next   = res_cnt;
            out_long_next  = res_long;
        end
        else if (gesture_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            db_reg        <= '0;
            pt_reg        <= '0;
            cnt_reg       <= COUNT_ZERO;
            long_cnt_reg  <= COUNT_ZERO;
            out_valid_reg <= 1'b0;
            debounce_reg  <= DEBOUNCE_RST;
            long_reg      <= LONG_RST;
            gap_reg       <= GAP_RST;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                db_reg       <= db_next;
                pt_reg       <= pt_next;
                cnt_reg      <= cnt_next;
                long_cnt_reg <= long_cnt_next;
            end
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_DEBOUNCE: debounce_reg <= cfg.data;
                    REG_LONG:     long_reg     <= cfg.data;
                    REG_GAP:      gap_reg      <= cfg.data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_cnt_reg  <= out_cnt_next;
        out_long_reg <= out_long_next;
    end

endmodule

/* rtl/bmpg_checker.sv */
// Port-level checks for the button gesture detector, bound to the top level.
// Depends on button_multi_press_gesture_defines.svh.
`include "button_multi_press_gesture_defines.svh"

module bmpg_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    `BMPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `BMPG_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without cause")
    `BMPG_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_valid && in_ready), "result without a sample transfer")

endmodule

bind button_multi_press_gesture bmpg_checker u_bmpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gesture_in.valid),
    .in_ready  (gesture_in.ready),
    .out_valid (gesture_out.valid),
    .out_ready (gesture_out.ready)
);

/* dv/tb_button_multi_press_gesture.sv */
// Testbench for the button gesture detector: feeds tick samples, follows the
// gesture state in a tracker class and checks every report. Needs bmpg_pkg,
// the channel interfaces in bmpg_if.sv and the button_multi_press_gesture RTL.
`timescale 1ns / 100ps

typedef enum logic [1:0] {ST_IDLE, ST_HOLD, ST_GAP, ST_REPEAT} gesture_phase_t;

typedef struct packed {
    logic [bmpg_pkg::COUNT_W-1:0] press_count;
    logic                         long_hold;
} gesture_report_t;

class gesture_tracker_t;
    logic [bmpg_pkg::CFG_W-1:0]   db_ticks;
    logic [bmpg_pkg::CFG_W-1:0]   long_ticks;
    logic [bmpg_pkg::CFG_W-1:0]   gap_ticks;
    gesture_phase_t               state;
    logic [15:0]                  db_timer;
    logic [15:0]                  ph_timer;
    logic [bmpg_pkg::COUNT_W-1:0] count;
    logic [bmpg_pkg::COUNT_W-1:0] long_count;
    gesture_report_t              pending_reports[$];
    int                           errors;
    int                           samples;
    int                           reports;

    function new();
        db_ticks   = bmpg_pkg::DEBOUNCE_RST;
        long_ticks = bmpg_pkg::LONG_RST;
        gap_ticks  = bmpg_pkg::GAP_RST;
        errors     = 0;
        samples    = 0;
        reports    = 0;
        clear();
    endfunction

    function void clear();
        state      = ST_IDLE;
        db_timer   = '0;
        ph_timer   = '0;
        count      = bmpg_pkg::COUNT_ZERO;
        long_count = bmpg_pkg::COUNT_ZERO;
    endfunction

    function logic [15:0] bump(logic [15:0] t);
        return (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

    // true when the press has been down long enough to count
    function bit debounce_hit(bit down);
        if (!down)
        begin
            db_timer = '0;
            return 1'b0;
        end
        db_timer = bump(db_timer);
        if (db_timer >= db_ticks)
        begin
            db_timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void add_report(logic [bmpg_pkg::COUNT_W-1:0] c, logic l);
        gesture_report_t r;
        r.press_count = c;
        r.long_hold   = l;
        pending_reports.push_back(r);
    endfunction

    function void set_reg(logic [bmpg_pkg::CFG_IDX_W-1:0] idx, logic [bmpg_pkg::CFG_W-1:0] val);
        case (idx)
            bmpg_pkg::REG_DEBOUNCE: db_ticks   = val;
            bmpg_pkg::REG_LONG:     long_ticks = val;
            bmpg_pkg::REG_GAP:      gap_ticks  = val;
            default: ;
        endcase
    endfunction

    function void take_sample(bit down);
        logic [bmpg_pkg::COUNT_W-1:0] c;
        samples++;
        case (state)
            ST_IDLE:
                if (debounce_hit(down))
                begin
                    state    = ST_HOLD;
                    ph_timer = '0;
                    count    = bmpg_pkg::COUNT_ONE;
                end
            ST_HOLD:
                if (down)
                begin
                    ph_timer = bump(ph_timer);
                    if (ph_timer >= long_ticks)
                    begin
                        long_count = count;
                        state      = ST_REPEAT;
                        ph_timer   = '0;
                        db_timer   = '0;
                        add_report(count, 1'b1);
                    end
                end
                else if (count >= bmpg_pkg::COUNT_TRIPLE)
                begin
                    clear();
                    add_report(bmpg_pkg::COUNT_TRIPLE, 1'b0);
                end
                else
                begin
                    state    = ST_GAP;
                    ph_timer = '0;
                    db_timer = '0;
                end
            ST_GAP:
                if (db_timer == '0 && ph_timer >= gap_ticks)
                begin
                    // window over: report, then treat this tick as idle
                    c = count;
                    clear();
                    if (debounce_hit(down))
                    begin
                        state    = ST_HOLD;
                        ph_timer = '0;
                        count    = bmpg_pkg::COUNT_ONE;
                    end
                    add_report(c, 1'b0);
                end
                else
                begin
                    ph_timer = bump(ph_timer);
                    if (debounce_hit(down))
                    begin
                        state    = ST_HOLD;
                        ph_timer = '0;
                        count    = count + bmpg_pkg::COUNT_ONE;
                    end
                end
            ST_REPEAT:
                if (!down)
                begin
                    clear();
                    add_report(bmpg_pkg::COUNT_ZERO, 1'b0);
                end
                else if (db_timer < db_ticks)
                    db_timer = bump(db_timer);
                else
                begin
                    ph_timer = bump(ph_timer);
                    if (ph_timer >= long_ticks)
                    begin
                        db_timer = '0;
                        ph_timer = '0;
                        add_report(long_count, 1'b1);
                    end
                end
            default: clear();
        endcase
    endfunction

    function void check_report(logic [bmpg_pkg::COUNT_W-1:0] c, logic l);
        gesture_report_t exp_r;
        reports++;
        if (pending_reports.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected report, expected none, got press_count %0d long_hold %0d",
                     $time, c, l);
            return;
        end
        exp_r = pending_reports.pop_front();
        if (c !== exp_r.press_count)
        begin
            errors++;
            $display("%0t: press_count expected %0d got %0d", $time, exp_r.press_count, c);
        end
        if (l !== exp_r.long_hold)
        begin
            errors++;
            $display("%0t: long_hold expected %0d got %0d", $time, exp_r.long_hold, l);
        end
    endfunction

    function int outstanding();
        return pending_reports.size();
    endfunction
endclass

module tb_button_multi_press_gesture;
    localparam logic [bmpg_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int LEN_CAP       = 100;
    localparam int SETTLE_CYCLES = 4;

    logic clk;
    logic rst_n;
    bit   calm;
    int   settings;

    bmpg_in_if  in_ch();
    bmpg_out_if out_ch();
    bmpg_cfg_if cfg_ch();

    gesture_tracker_t tracker;

    button_multi_press_gesture dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .gesture_in  (in_ch),
        .gesture_out (out_ch),
        .cfg         (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_report(out_ch.press_count, out_ch.long_hold);
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end

    task automatic send_sample(input bit down);
        while (!calm && $urandom_range(99) < 37)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.pressed <= down;
        do @(posedge clk); while (!in_ch.ready);
        tracker.take_sample(down);
    endtask

    task automatic write_reg(input logic [bmpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bmpg_pkg::CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        tracker.set_reg(idx, val);
        @(posedge clk);
    endtask

    // drain outstanding reports, then let the pipeline empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic play_bits(input string pattern);
        for (int i = 0; i < pattern.len(); i++)
            send_sample(pattern[i] == "1");
    endtask

    task automatic play_level(input bit level, input int n);
        for (int i = 0; i < n; i++)
            send_sample(($urandom_range(39) == 0) ? !level : level);
    endtask

    function automatic int around(input int anchor);
        int n;
        n = anchor + int'($urandom_range(4)) - 2;
        return (n < 1) ? 1 : n;
    endfunction

    function automatic int capped(input int n);
        return (n > LEN_CAP) ? int'($urandom_range(LEN_CAP, 1)) : n;
    endfunction

    function automatic int hold_len();
        int db;
        int cyc;
        int n;
        db  = int'(tracker.db_ticks);
        cyc = int'(tracker.db_ticks) + int'(tracker.long_ticks);
        case ($urandom_range(5))
            0: n = $urandom_range((db > 1) ? db - 1 : 1, 1);
            1: n = around(db);
            2: n = db + $urandom_range(tracker.long_ticks);
            3: n = around(cyc);
            4: n = around(cyc * (1 + $urandom_range(1, 2)));
            default: n = $urandom_range(2 * cyc + 2, 1);
        endcase
        return capped(n);
    endfunction

    function automatic int release_len();
        int db;
        int gp;
        int n;
        db = int'(tracker.db_ticks);
        gp = int'(tracker.gap_ticks);
        case ($urandom_range(4))
            0: n = $urandom_range(3, 1);
            1: n = around(gp);
            2: n = around(gp + db);
            3: n = $urandom_range(gp + db + 2, 1);
            default: n = gp + db + $urandom_range(20, 1);
        endcase
        return capped(n);
    endfunction

    task automatic play_gesture();
        int presses;
        if ($urandom_range(7) == 0)
        begin
            // chatter
            presses = $urandom_range(30, 1);
            for (int i = 0; i < presses; i++)
                send_sample(1'($urandom_range(1)));
        end
        else
        begin
            presses = $urandom_range(4, 1);
            for (int p = 0; p < presses; p++)
            begin
                play_level(1'b1, hold_len());
                play_level(1'b0, release_len());
            end
        end
    endtask

    task automatic play_budget(input int budget);
        int target;
        target = tracker.samples + budget;
        while (tracker.samples < target)
            play_gesture();
    endtask

    task automatic run_phase(input int db, input int lg, input int gp, input int budget,
                             input bit quiet);
        settle();
        write_reg(bmpg_pkg::REG_DEBOUNCE, 16'(db));
        write_reg(bmpg_pkg::REG_LONG, 16'(lg));
        write_reg(bmpg_pkg::REG_GAP, 16'(gp));
        settings++;
        calm = quiet;
        play_budget(budget);
        calm = 1'b0;
    endtask

    initial
    begin
        tracker        = new();
        calm           = 1'b0;
        settings       = 1;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.pressed  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = bmpg_pkg::REG_DEBOUNCE;
        cfg_ch.data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values in force
        play_budget(300);

        settle();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(bmpg_pkg::REG_DEBOUNCE, 16'd2);
        write_reg(bmpg_pkg::REG_LONG, 16'd2);
        write_reg(bmpg_pkg::REG_GAP, 16'd2);
        settings++;
        // flush to idle; triple short press; long hold with repeat and release;
        // gap-end debounce then gap expiry starting a fresh debounce
        play_bits("0000");
        play_bits("110110110");
        play_bits("111111110");
        play_bits("11001100010");

        run_phase(3, 5, 4, 250, 1'b0);
        run_phase(1, 1, 1, 150, 1'b0);
        run_phase(0, 0, 0, 150, 1'b0);
        run_phase(4, 8, 6, 250, 1'b1);
        run_phase(1, 65535, 1, 120, 1'b0);
        run_phase(65535, 1, 65535, 100, 1'b0);
        run_phase(2, 3, 65535, 150, 1'b0);
        run_phase(6, 12, 3, 250, 1'b0);
        settle();

        $display("Ran %0d tick samples over %0d register settings; %0d gesture reports checked",
                 tracker.samples, settings, tracker.reports);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
